// File: rtl/core/rmu_pkg.sv
// Shared definitions for the RV64M multiply unit: operation codes,
// result selection type and the operation decoder. No dependencies.
`default_nettype none

package rmu_pkg;

	localparam int OpWidth   = 7;
	localparam int XLen      = 64;
	localparam int HalfLen   = XLen / 2;
	localparam int ProdWidth = 2 * HalfLen;

	localparam logic [OpWidth-1:0] OPC_MUL    = 7'h00;
	localparam logic [OpWidth-1:0] OPC_MULH   = 7'h01;
	localparam logic [OpWidth-1:0] OPC_MULHSU = 7'h02;
	localparam logic [OpWidth-1:0] OPC_MULHU  = 7'h03;
	localparam logic [OpWidth-1:0] OPC_MULW   = 7'h04;
	localparam logic [OpWidth-1:0] OPC_MULW7  = 7'h0C;

	// Which part of the product forms the result
	typedef enum logic [1:0] {
		SEL_LOW  = 2'd0,
		SEL_HIGH = 2'd1,
		SEL_WORD = 2'd2,
		SEL_NONE = 2'd3
	} rmu_sel_t;

	// Control carried from the partial-product stage to the combine stage
	typedef struct packed {
		rmu_sel_t sel;
	} rmu_ctrl_t;

	function automatic rmu_sel_t rmu_decode(input logic [OpWidth-1:0] op);
		rmu_sel_t sel;
		unique case (op)
			OPC_MUL:                        sel = SEL_LOW;
			OPC_MULH, OPC_MULHSU, OPC_MULHU: sel = SEL_HIGH;
			OPC_MULW, OPC_MULW7:            sel = SEL_WORD;
			default:                        sel = SEL_NONE;
		endcase
		return sel;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/rmu_pp_stage.sv
// Partial-product stage: four 32x32 unsigned products, the signed
// correction term and the decoded result select. Uses rmu_pkg.
`default_nettype none

module rmu_pp_stage
	import rmu_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   load,
	input  wire logic [OpWidth-1:0]     operation,
	input  wire logic [XLen-1:0]        operand_a,
	input  wire logic [XLen-1:0]        operand_b,
	output logic      [ProdWidth-1:0]   p00_s2,
	output logic      [ProdWidth-1:0]   p01_s2,
	output logic      [ProdWidth-1:0]   p10_s2,
	output logic      [ProdWidth-1:0]   p11_s2,
	output logic      [XLen-1:0]        corr_s2,
	output rmu_ctrl_t                   ctrl_s2
);

	logic [XLen-1:0]    a_eff;
	logic [HalfLen-1:0] a0, a1, b0, b1;
	logic [XLen-1:0]    corr_a, corr_b;
	logic               fix_a, fix_b;

	always_comb begin
		// MULW7 uses only the low seven bits of the first operand
		if (operation == OPC_MULW7) begin
			a_eff = {{(XLen-7){1'b0}}, operand_a[6:0]};
		end else begin
			a_eff = operand_a;
		end
		a0 = a_eff[HalfLen-1:0];
		a1 = a_eff[XLen-1:HalfLen];
		b0 = operand_b[HalfLen-1:0];
		b1 = operand_b[XLen-1:HalfLen];

		// Subtract the other operand for each negative signed operand
		fix_a  = operand_a[XLen-1] && (operation == OPC_MULH || operation == OPC_MULHSU);
		fix_b  = operand_b[XLen-1] && (operation == OPC_MULH);
		corr_a = fix_a ? operand_b : '0;
		corr_b = fix_b ? operand_a : '0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			p00_s2       <= ProdWidth'(a0) * ProdWidth'(b0);
			p01_s2       <= ProdWidth'(a0) * ProdWidth'(b1);
			p10_s2       <= ProdWidth'(a1) * ProdWidth'(b0);
			p11_s2       <= ProdWidth'(a1) * ProdWidth'(b1);
			corr_s2      <= corr_a + corr_b;
			ctrl_s2.sel  <= rmu_decode(operation);
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/rmu_combine_stage.sv
// Combine stage: sums the partial products into the 128-bit product and
// registers the selected 64-bit result. Uses rmu_pkg.
`default_nettype none

module rmu_combine_stage
	import rmu_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 load,
	input  wire logic [ProdWidth-1:0] p00_s2,
	input  wire logic [ProdWidth-1:0] p01_s2,
	input  wire logic [ProdWidth-1:0] p10_s2,
	input  wire logic [ProdWidth-1:0] p11_s2,
	input  wire logic [XLen-1:0]      corr_s2,
	input  wire rmu_ctrl_t            ctrl_s2,
	output logic      [XLen-1:0]      product_q,
	output logic                      known_q
);

	logic [HalfLen+1:0] mid;
	logic [XLen-1:0]    lo, hi, res;
	logic               known;

	always_comb begin
		mid = {2'b00, p00_s2[ProdWidth-1:HalfLen]}
			+ {2'b00, p01_s2[HalfLen-1:0]}
			+ {2'b00, p10_s2[HalfLen-1:0]};
		lo  = {mid[HalfLen-1:0], p00_s2[HalfLen-1:0]};
		hi  = p11_s2
			+ {{HalfLen{1'b0}}, p01_s2[ProdWidth-1:HalfLen]}
			+ {{HalfLen{1'b0}}, p10_s2[ProdWidth-1:HalfLen]}
			+ {{(XLen-2){1'b0}}, mid[HalfLen+1:HalfLen]}
			- corr_s2;

		known = 1'b1;
		unique case (ctrl_s2.sel)
			SEL_LOW:  res = lo;
			SEL_HIGH: res = hi;
			SEL_WORD: res = {{HalfLen{lo[HalfLen-1]}}, lo[HalfLen-1:0]};
			default: begin
				res   = '0;
				known = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			product_q <= res;
			known_q   <= known;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/rv64_multiply_unit.sv
// RV64M multiply unit top level: input register, handshake control and
// the two arithmetic stages. Uses rmu_pkg, rmu_pp_stage, rmu_combine_stage.
//
//   Channel | Handshake          | Payload
//   --------+--------------------+-----------------------------------
//   in      | in_valid, in_stall | operation, operand_a, operand_b
//   out     | out_valid,out_stall| product_out, op_known
//
// One request enters per cycle while in_stall is low; a taken request passes
// the input register, the partial-product register and the result register
// before out_valid rises. The depth is set by the split of the 64x64 product
// into four 32x32 multipliers whose outputs are registered before the final add.
// arst_n clears the valid bits of all three stages; payload holds no reset.
// A stalled result holds in place while earlier stages still fill bubbles,
// so in_stall rises only when every stage holds a request.
`default_nettype none

module rv64_multiply_unit
	import rmu_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [OpWidth-1:0]  operation,
	input  wire logic [XLen-1:0]     operand_a,
	input  wire logic [XLen-1:0]     operand_b,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic      [XLen-1:0]     product_out,
	output logic                     op_known
);

	logic                 valid_s1, valid_s2, valid_q;
	logic [OpWidth-1:0]   op_s1;
	logic [XLen-1:0]      a_s1, b_s1;
	logic                 load1, load2, load3;

	logic [ProdWidth-1:0] p00_s2, p01_s2, p10_s2, p11_s2;
	logic [XLen-1:0]      corr_s2;
	rmu_ctrl_t            ctrl_s2;

	// Advance a stage when the next one is empty or moving on
	always_comb begin
		load3    = valid_s2 && (!valid_q || !out_stall);
		load2    = valid_s1 && (!valid_s2 || load3);
		in_stall = valid_s1 && !load2;
		load1    = in_valid && !in_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (load1) begin
				valid_s1 <= 1'b1;
			end else if (load2) begin
				valid_s1 <= 1'b0;
			end
			if (load2) begin
				valid_s2 <= 1'b1;
			end else if (load3) begin
				valid_s2 <= 1'b0;
			end
			if (load3) begin
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (load1) begin
			op_s1 <= operation;
			a_s1  <= operand_a;
			b_s1  <= operand_b;
		end
	end

	rmu_pp_stage u_pp (
		.clk       (clk),
		.load      (load2),
		.operation (op_s1),
		.operand_a (a_s1),
		.operand_b (b_s1),
		.p00_s2    (p00_s2),
		.p01_s2    (p01_s2),
		.p10_s2    (p10_s2),
		.p11_s2    (p11_s2),
		.corr_s2   (corr_s2),
		.ctrl_s2   (ctrl_s2)
	);

	rmu_combine_stage u_comb (
		.clk       (clk),
		.load      (load3),
		.p00_s2    (p00_s2),
		.p01_s2    (p01_s2),
		.p10_s2    (p10_s2),
		.p11_s2    (p11_s2),
		.corr_s2   (corr_s2),
		.ctrl_s2   (ctrl_s2),
		.product_q (product_out),
		.known_q   (op_known)
	);

	assign out_valid = valid_q;

	// A taken request always lands in the input register
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted request not captured");

	// A request in stage two moves out when the output is free
	a_s2_drains: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_stall |=> out_valid)
		else $error("stage two request did not reach the output");

	// A stalled result is never dropped
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result lost");

	// Unknown codes give a zero result
	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !op_known |-> product_out == '0)
		else $error("unknown operation produced nonzero result");

endmodule

`default_nettype wire

// File: verif/rv64_multiply_unit_test.sv
// Self-checking testbench for the RV64M multiply unit: directed corner requests,
// then random phases with sender idling, receiver stalls and a long output hold.
// Depends on rmu_pkg and rv64_multiply_unit.
`default_nettype none

module rv64_multiply_unit_test;
	import rmu_pkg::*;

	// One request as offered on the input channel
	typedef struct {
		logic [OpWidth-1:0] op;
		logic [XLen-1:0]    a;
		logic [XLen-1:0]    b;
	} mul_req_t;

	// One result as expected on the output channel
	typedef struct {
		logic [XLen-1:0] value;
		logic            known;
	} mul_result_t;

	localparam logic [OpWidth-1:0] KNOWN_OPS [6] = '{
		OPC_MUL, OPC_MULH, OPC_MULHSU, OPC_MULHU, OPC_MULW, OPC_MULW7
	};
	localparam logic [XLen-1:0] ALL_ONES = {XLen{1'b1}};
	localparam logic [XLen-1:0] MIN_NEG  = {1'b1, {(XLen-1){1'b0}}};
	localparam logic [XLen-1:0] MAX_POS  = {1'b0, {(XLen-1){1'b1}}};
	localparam int HOLD_CYCLES = 60;
	localparam int MAX_REPORTS = 40;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [OpWidth-1:0] operation;
	logic [XLen-1:0]    operand_a;
	logic [XLen-1:0]    operand_b;
	logic               out_valid;
	logic               out_stall;
	logic [XLen-1:0]    product_out;
	logic               op_known;

	mul_req_t    pending_reqs[$];
	mul_result_t expected_products[$];

	int unsigned reqs_queued = 0;
	int unsigned reqs_taken = 0;
	int unsigned error_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	bit          req_taken = 0;
	bit          hold_go = 0;
	bit          hold_off = 0;

	rv64_multiply_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.operand_a   (operand_a),
		.operand_b   (operand_b),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.product_out (product_out),
		.op_known    (op_known)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Compute the destination value and the known flag for one request.
	// Sign-extend the operands to 128 bits so that a plain unsigned multiply
	// yields the two's-complement product for every signedness mix.
	function automatic mul_result_t predict_product(logic [OpWidth-1:0] op,
			logic [XLen-1:0] a, logic [XLen-1:0] b);
		mul_result_t     r;
		logic [127:0]    ua, ub, sa, sb, full;
		logic [XLen-1:0] low;
		ua = {64'b0, a};
		ub = {64'b0, b};
		sa = {{64{a[XLen-1]}}, a};
		sb = {{64{b[XLen-1]}}, b};
		r.known = 1'b1;
		r.value = '0;
		case (op)
			OPC_MUL: begin
				low = a * b;
				r.value = low;
			end
			OPC_MULH: begin
				full = sa * sb;
				r.value = full[127:64];
			end
			OPC_MULHSU: begin
				full = sa * ub;
				r.value = full[127:64];
			end
			OPC_MULHU: begin
				full = ua * ub;
				r.value = full[127:64];
			end
			OPC_MULW: begin
				low = a * b;
				r.value = {{32{low[31]}}, low[31:0]};
			end
			OPC_MULW7: begin
				// only the low seven bits of the first operand take part
				low = {57'b0, a[6:0]} * b;
				r.value = {{32{low[31]}}, low[31:0]};
			end
			default: begin
				r.value = '0;
				r.known = 1'b0;
			end
		endcase
		return r;
	endfunction

	// Print one mismatch line (up to a cap) and count it.
	task automatic report_mismatch(string what, logic [XLen-1:0] got, logic [XLen-1:0] want);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
	endtask

	task automatic push_req(logic [OpWidth-1:0] op, logic [XLen-1:0] a, logic [XLen-1:0] b);
		mul_req_t r;
		r.op = op;
		r.a = a;
		r.b = b;
		pending_reqs.push_back(r);
		reqs_queued++;
	endtask

	// Draw an operand: full-width random bits half the time, otherwise a corner
	// value, a small magnitude of either sign, a single set bit or an upper half of ones.
	function automatic logic [XLen-1:0] pick_operand();
		logic [XLen-1:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(9))
			5: begin
				case ($urandom_range(4))
					0: v = '0;
					1: v = 64'd1;
					2: v = ALL_ONES;
					3: v = MIN_NEG;
					default: v = MAX_POS;
				endcase
			end
			6: v = 64'($urandom_range(255));
			7: v = -64'($urandom_range(255));
			8: v = 64'd1 << $urandom_range(63);
			9: v = {32'hFFFF_FFFF, $urandom};
			default: ;
		endcase
		return v;
	endfunction

	// Queue n random requests; most carry a handled code, the rest any code.
	task automatic push_random(int n);
		logic [OpWidth-1:0] op;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 80)
				op = KNOWN_OPS[$urandom_range(5)];
			else
				op = OpWidth'($urandom_range(127));
			push_req(op, pick_operand(), pick_operand());
		end
	endtask

	// Hold until every queued request has been taken and every result seen.
	task automatic wait_for_drain();
		while (reqs_taken != reqs_queued || expected_products.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Input driver: change signals on the falling edge only. Present a new
	// request when the current one was taken (or none is up); the decision
	// to idle never looks at in_stall. Drive out_stall from the same block
	// so each signal gets exactly one update per edge.
	always @(negedge clk) begin : drive_req
		mul_req_t nxt;
		if (arst_n) begin
			if (!in_valid || req_taken) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_reqs.pop_front();
					in_valid  <= 1'b1;
					operation <= nxt.op;
					operand_a <= nxt.a;
					operand_b <= nxt.b;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Monitor: sample both handshakes on the rising edge. Record the expected
	// result of each accepted request, then check each accepted result
	// against the oldest expectation.
	always @(posedge clk) begin : watch_ports
		mul_result_t want;
		req_taken = 1'b0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_products.push_back(predict_product(operation, operand_a, operand_b));
				reqs_taken++;
				req_taken = 1'b1;
			end
			if (out_valid && !out_stall) begin
				if (expected_products.size() == 0) begin
					report_mismatch("unexpected result", product_out, '0);
				end else begin
					want = expected_products.pop_front();
					if (product_out !== want.value)
						report_mismatch("product_out", product_out, want.value);
					if (op_known !== want.known)
						report_mismatch("op_known", 64'(op_known), 64'(want.known));
				end
			end
		end
	end

	// Long receiver hold: once armed, keep out_stall high for HOLD_CYCLES
	// while the driver keeps offering, so the pipe fills and
	// pushes back on the input side.
	initial begin : long_hold
		wait (hold_go);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin : run_limit
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		operation = '0;
		operand_a = '0;
		operand_b = '0;
		out_stall = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners, back to back with no idling
		push_req(OPC_MUL, '0, '0);
		push_req(OPC_MUL, ALL_ONES, ALL_ONES);
		push_req(OPC_MUL, MAX_POS, 64'd2);
		push_req(OPC_MULH, MIN_NEG, MIN_NEG);
		push_req(OPC_MULH, ALL_ONES, ALL_ONES);
		push_req(OPC_MULH, MAX_POS, MIN_NEG);
		push_req(OPC_MULH, MAX_POS, MAX_POS);
		push_req(OPC_MULHSU, ALL_ONES, ALL_ONES);
		push_req(OPC_MULHSU, MIN_NEG, ALL_ONES);
		push_req(OPC_MULHSU, MAX_POS, ALL_ONES);
		push_req(OPC_MULHU, ALL_ONES, ALL_ONES);
		push_req(OPC_MULHU, MIN_NEG, 64'd2);
		push_req(OPC_MULW, 64'h0000_0000_8000_0000, 64'd1);
		push_req(OPC_MULW, 64'hFFFF_FFFF_7FFF_FFFF, 64'd1);
		push_req(OPC_MULW, ALL_ONES, ALL_ONES);
		push_req(OPC_MULW7, ALL_ONES, ALL_ONES);
		push_req(OPC_MULW7, 64'hFFFF_FFFF_FFFF_FF80, ALL_ONES);
		push_req(OPC_MULW7, 64'h7F, 64'h0000_0000_0102_0409);
		push_req(OPC_MULW7, 64'h40, 64'h0000_0000_0200_0000);
		// unhandled codes, including ones that alias a handled code in low bits
		push_req(7'h05, ALL_ONES, ALL_ONES);
		push_req(7'h08, ALL_ONES, ALL_ONES);
		push_req(7'h0D, MIN_NEG, 64'd3);
		push_req(7'h44, 64'd5, 64'd7);
		push_req(7'h7F, ALL_ONES, ALL_ONES);
		push_random(276);
		wait_for_drain();

		// Sender mostly idle
		send_idle_pct = 78;
		push_random(300);
		wait_for_drain();

		// Receiver mostly stalled
		send_idle_pct = 0;
		recv_stall_pct = 78;
		push_random(300);
		wait_for_drain();

		// Both sides idle now and then
		send_idle_pct = 23;
		recv_stall_pct = 23;
		push_random(300);
		wait_for_drain();

		// Full pressure: arm the long hold, then stream requests into it
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_go = 1'b1;
		push_random(100);
		wait_for_drain();

		// Let any stray result surface before the verdict
		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire
